### rtl/rwcp_pkg.sv
// Package for the wall-column projection block: request payload types, config
// register indexes, field widths and the fixed-point cosine coefficients.
// No dependencies.
package rwcp_pkg;

    // Field widths of the request and result payloads
    localparam int DIST_W   = 24;
    localparam int ANG_W    = 12;
    localparam int COORD_W  = 16;
    localparam int HT_W     = 14;
    localparam int TOPC_W   = 9;
    localparam int BOTC_W   = 10;
    localparam int TEX_W    = 6;
    localparam int PLANE_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURED = 2'd2;

    localparam logic [PLANE_W-1:0] PLANE_RESET = 16'd443;

    // Saturated wall height
    localparam logic [HT_W-1:0] HEIGHT_MAX = 14'h3FFF;

    // Q30 cosine polynomial, evaluated by Horner steps from the highest term
    localparam int Q_W       = 31;
    localparam int COS_STEPS = 5;

    localparam logic [Q_W-1:0] COS_C4 = 31'd27059;
    // Constant subtracted at each Horner step, the last one being 1.0 in Q30
    localparam logic [Q_W-1:0] COS_SUB [COS_STEPS] = '{
        31'd987048, 31'd22401991, 31'd272375566, 31'd1324675880, 31'd1073741824
    };

    typedef struct packed {
        logic [DIST_W-1:0]  ray_distance;
        logic [ANG_W-1:0]   ray_angle;
        logic               hit_vertical;
        logic [COORD_W-1:0] hit_x;
        logic [COORD_W-1:0] hit_y;
    } t_ray_in;

    typedef struct packed {
        logic signed [HT_W-1:0] wall_top_raw;
        logic [HT_W-1:0]        wall_bottom_raw;
        logic [TOPC_W-1:0]      wall_top_clamped;
        logic [BOTC_W-1:0]      wall_bottom_clamped;
        logic [HT_W-1:0]        wall_height;
        logic                   sky_present;
        logic                   floor_present;
        logic                   wall_shade;
        logic [TEX_W-1:0]       texture_column;
    } t_col_out;

endpackage

### rtl/raycast_wall_column_projection.sv
// Top level of the wall-column projection pipeline with its output skid stage.
// Depends on rwcp_pkg for payload types, widths and cosine coefficients.
//
// One ray request per clock cycle is taken while o_stall is low, and one column
// result per request is given, in order. The stages, in order: the angle and
// its square, the Horner steps of the quarter-wave cosine (one 31x31 multiplier
// each), the distance correction, the height saturation test and the restoring
// divider (one quotient bit per stage), then the row formatting stage. A skid
// register behind the last stage holds one result while the sink stalls;
// o_stall is raised only while it is full.
// Configuration writes must be made while the pipeline is empty.
module raycast_wall_column_projection #(
    parameter int SCREEN_HEIGHT = 512,
    parameter int TILE_PX       = 64,
    parameter int ANGLE_BITS    = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Ray requests
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  rwcp_pkg::t_ray_in                      i_ray,
    // Column results
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output rwcp_pkg::t_col_out                     o_col,
    // Configuration writes
    input  logic                                   i_cfg_we,
    input  logic [rwcp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rwcp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import rwcp_pkg::*;

    // Stage layout
    localparam int ST_ANG  = 0;
    localparam int ST_U    = 1;
    localparam int ST_POLY = 2;
    localparam int ST_CD   = ST_POLY + COS_STEPS;
    localparam int ST_SAT  = ST_CD + 1;
    localparam int ST_DIV  = ST_SAT + 1;
    localparam int ST_OUT  = ST_DIV + HT_W;
    localparam int NS      = ST_OUT + 1;

    // Angle arithmetic
    localparam int AW      = ANGLE_BITS;
    localparam int T_SHIFT = 30 - (AW - 2);
    localparam logic [AW-2:0] QUARTER = (AW-1)'(1) << (AW - 2);

    // Texture column: x mod TILE_PX by reciprocal, exact for 16-bit x
    localparam int RECIP_W = 30;
    localparam int TPROD_W = COORD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] TEX_RECIP =
        RECIP_W'(((64'd1 << 32) + 64'(TILE_PX) - 64'd1) / 64'(TILE_PX));
    localparam int TQ_W = TPROD_W - 32;

    // Division widths: numerator TILE_PX * plane * 256, divisor Q8 distance
    localparam int NW    = 24 + $clog2(TILE_PX + 1);
    localparam int DIV_W = DIST_W + HT_W;

    // Screen row constants
    localparam logic [15:0] SH16   = 16'(SCREEN_HEIGHT);
    localparam logic [15:0] HALF16 = 16'(SCREEN_HEIGHT / 2);

    typedef struct packed {
        logic             shade;
        logic [TEX_W-1:0] tex;
    } t_side;

    // Configuration registers
    logic [ANG_W-1:0]   r_heading;
    logic [PLANE_W-1:0] r_ppd;
    logic               r_textured;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading  <= '0;
            r_ppd      <= PLANE_RESET;
            r_textured <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADING:  r_heading  <= i_cfg_data[ANG_W-1:0];
                CFG_PLANE:    r_ppd      <= i_cfg_data[PLANE_W-1:0];
                CFG_TEXTURED: r_textured <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Pipeline control: the whole pipe advances unless the skid is full
    logic [NS-1:0] r_v;
    logic          r_skid_v;
    t_col_out      r_skid;
    t_col_out      r_out;
    logic          w_en;

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // Stage registers
    logic [Q_W-1:0]     r_t;
    logic [COORD_W-1:0] r_sel;
    logic [TPROD_W-1:0] r_tprod;
    logic               r_tex_on;
    logic               r_shade0;
    logic [DIST_W-1:0]  r_dist [ST_ANG:ST_CD-1];
    logic [Q_W-1:0]     r_u    [ST_U:ST_CD-2];
    logic [Q_W-1:0]     r_acc  [ST_POLY:ST_CD-1];
    t_side              r_side [ST_U:ST_OUT-1];
    logic [DIST_W-1:0]  r_cd   [ST_CD:ST_OUT-2];
    logic [NW-1:0]      r_rem  [ST_SAT:ST_OUT-2];
    logic [HT_W-1:0]    r_q    [ST_SAT:ST_OUT-1];
    logic               r_sat  [ST_SAT:ST_OUT-1];

    // Stage 0: angle from heading, folded into one quarter turn
    logic [AW-1:0]      w_d;
    logic [AW-2:0]      w_arg;
    logic [COORD_W-1:0] w_sel;

    assign w_d   = AW'(i_ray.ray_angle) - AW'(r_heading);
    assign w_arg = w_d[AW-2] ? (QUARTER - (AW-1)'(w_d[AW-3:0]))
                             : (AW-1)'(w_d[AW-3:0]);
    assign w_sel = i_ray.hit_vertical ? i_ray.hit_y : i_ray.hit_x;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t          <= Q_W'(w_arg) << T_SHIFT;
            r_dist[ST_ANG] <= i_ray.ray_distance;
            r_sel        <= w_sel;
            r_tprod      <= TPROD_W'(w_sel) * TPROD_W'(TEX_RECIP);
            r_tex_on     <= r_textured;
            r_shade0     <= i_ray.hit_vertical;
        end
    end

    // Stage 1: square of the angle in Q30, texture remainder
    logic [2*Q_W-1:0]   w_tsq;
    logic [TQ_W-1:0]    w_tq;
    logic [COORD_W-1:0] w_tqt;
    logic [COORD_W-1:0] w_trem;

    assign w_tsq  = (2*Q_W)'(r_t) * (2*Q_W)'(r_t);
    assign w_tq   = r_tprod[TPROD_W-1:32];
    assign w_tqt  = COORD_W'(RECIP_W'(w_tq) * RECIP_W'(TILE_PX));
    assign w_trem = r_sel - w_tqt;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u[ST_U]        <= w_tsq[2*Q_W-2:30];
            r_dist[ST_U]     <= r_dist[ST_ANG];
            r_side[ST_U].shade <= r_shade0;
            r_side[ST_U].tex   <= r_tex_on ? TEX_W'(w_trem) : '0;
        end
    end

    // Horner steps of the cosine, one multiply and floored subtract each
    for (genvar p = 0; p < COS_STEPS; p++) begin : g_poly
        localparam int S = ST_POLY + p;
        logic [Q_W-1:0]   w_mul;
        logic [2*Q_W-1:0] w_prod;
        logic [Q_W-1:0]   w_term;

        if (p == 0) begin : g_first
            assign w_mul = COS_C4;
        end else begin : g_next
            assign w_mul = r_acc[S-1];
        end

        assign w_prod = (2*Q_W)'(r_u[S-1]) * (2*Q_W)'(w_mul);
        assign w_term = w_prod[2*Q_W-2:30];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_acc[S]  <= (COS_SUB[p] > w_term) ? (COS_SUB[p] - w_term) : '0;
                r_dist[S] <= r_dist[S-1];
                r_side[S] <= r_side[S-1];
            end
        end

        if (S < ST_CD - 1) begin : g_carry_u
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_u[S] <= r_u[S-1];
                end
            end
        end
    end

    // Round the cosine to Q16 and correct the distance
    logic [Q_W-1:0]          w_rnd;
    logic [16:0]             w_cos;
    logic [DIST_W+16:0]      w_cdp;

    assign w_rnd = r_acc[ST_CD-1] + Q_W'(8192);
    assign w_cos = (w_rnd[Q_W-1:14] > 17'd65536) ? 17'd65536 : w_rnd[Q_W-1:14];
    assign w_cdp = (DIST_W+17)'(r_dist[ST_CD-1]) * (DIST_W+17)'(w_cos);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd[ST_CD]   <= w_cdp[DIST_W+15:16];
            r_side[ST_CD] <= r_side[ST_CD-1];
        end
    end

    // Saturation test: quotient would not fit the height field (zero distance too)
    logic [NW-1:0] w_num;
    logic          w_sat;

    assign w_num = (NW'(r_ppd) * NW'(TILE_PX)) << 8;
    assign w_sat = DIV_W'(w_num) >= (DIV_W'(r_cd[ST_CD]) << HT_W);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[ST_SAT]  <= w_num;
            r_q[ST_SAT]    <= '0;
            r_sat[ST_SAT]  <= w_sat;
            r_cd[ST_SAT]   <= r_cd[ST_CD];
            r_side[ST_SAT] <= r_side[ST_CD];
        end
    end

    // Restoring divider, one quotient bit per stage from the top
    for (genvar j = 0; j < HT_W; j++) begin : g_div
        localparam int S = ST_DIV + j;
        localparam int B = HT_W - 1 - j;
        localparam logic [HT_W-1:0] QBIT = HT_W'(1) << B;
        logic [DIV_W-1:0] w_dsh;
        logic [DIV_W-1:0] w_rem;
        logic             w_ge;

        assign w_dsh = DIV_W'(r_cd[S-1]) << B;
        assign w_rem = DIV_W'(r_rem[S-1]);
        assign w_ge  = w_rem >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_q[S]    <= w_ge ? (r_q[S-1] | QBIT) : r_q[S-1];
                r_sat[S]  <= r_sat[S-1];
                r_side[S] <= r_side[S-1];
            end
        end

        if (j < HT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[S] <= w_ge ? NW'(w_rem - w_dsh) : r_rem[S-1];
                    r_cd[S]  <= r_cd[S-1];
                end
            end
        end
    end

    // Row formatting into the last stage
    logic [HT_W-1:0]    w_height;
    logic [HT_W-2:0]    w_half;
    logic signed [15:0] w_top;
    logic [15:0]        w_bot;

    assign w_height = r_sat[ST_OUT-1] ? HEIGHT_MAX : r_q[ST_OUT-1];
    assign w_half   = w_height[HT_W-1:1];
    assign w_top    = $signed(HALF16) - $signed({3'b000, w_half});
    assign w_bot    = HALF16 + {3'b000, w_half};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.wall_top_raw        <= w_top[HT_W-1:0];
            r_out.wall_bottom_raw     <= w_bot[HT_W-1:0];
            r_out.wall_top_clamped    <= (w_top < 0) ? '0 : w_top[TOPC_W-1:0];
            r_out.wall_bottom_clamped <= (w_bot > SH16) ? BOTC_W'(SCREEN_HEIGHT)
                                                        : w_bot[BOTC_W-1:0];
            r_out.wall_height         <= w_height;
            r_out.sky_present         <= w_top > 0;
            r_out.floor_present       <= w_bot < SH16;
            r_out.wall_shade          <= r_side[ST_OUT-1].shade;
            r_out.texture_column      <= r_side[ST_OUT-1].tex;
        end
    end

    // Skid: catch the last stage's result when the sink stalls as the pipe moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_v[NS-1] && i_stall) begin
            r_skid_v <= 1'b1;
            r_skid   <= r_out;
        end
    end

    assign o_valid = r_skid_v || r_v[NS-1];
    assign o_col   = r_skid_v ? r_skid : r_out;

    // Skid fills only from a stalled valid result
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_v[NS-1] && i_stall))
        else $error("skid filled without a stalled result");

    // A full skid freezes the pipeline
    a_skid_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_v))
        else $error("pipeline moved while skid full");

    // Top and bottom rows sit symmetrically about the screen centre
    a_rows_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] |-> (HT_W'(r_out.wall_top_raw + r_out.wall_bottom_raw)
                       == HT_W'(2 * (SCREEN_HEIGHT / 2))))
        else $error("wall rows not symmetric about centre");

endmodule

### test/tb_raycast_wall_column_projection.sv
// Testbench for raycast_wall_column_projection: directed and random ray requests under
// several register settings, with each column result checked against a scoreboard model.
// Depends on rwcp_pkg for the request/result payload types and register indexes.
module tb_raycast_wall_column_projection;
    timeunit 1ns;
    timeprecision 1ps;

    import rwcp_pkg::*;

    localparam int SCREEN_H       = 512;
    localparam int TILE           = 64;
    localparam int DRAIN_CYCLES   = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 9;
    localparam int RAYS_PER_PHASE = 60;

    localparam longint unsigned Q30_ONE   = 64'd1073741824;
    localparam longint unsigned SLICE_MAX = 64'd16383;
    // Q30 polynomial terms for the quarter-wave cosine, lowest order first
    localparam longint unsigned POLY [5] = '{
        64'd1324675880, 64'd272375566, 64'd22401991, 64'd987048, 64'd27059
    };

    // Scoreboard: register copy, column projection model and queue of expected columns
    class column_scoreboard;
        t_col_out    pending_columns[$];
        int          errors;
        logic [11:0] heading;
        logic [15:0] plane;
        logic        textured;

        function new();
            errors   = 0;
            heading  = '0;
            plane    = 16'd443;
            textured = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == CFG_HEADING)
                heading = data[11:0];
            else if (idx == CFG_PLANE)
                plane = data;
            else if (idx == CFG_TEXTURED)
                textured = data[0];
        endfunction

        function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
            return (a * b) >> 30;
        endfunction

        function longint unsigned sub_clip(longint unsigned a, longint unsigned b);
            return (a > b) ? a - b : 64'd0;
        endfunction

        // Cosine magnitude of angle d in Q16, mirrored into the first quarter
        function longint unsigned cos_magnitude(logic [11:0] d);
            longint unsigned arg, t, u, acc;
            arg = d[10] ? 64'd1024 - 64'(d[9:0]) : 64'(d[9:0]);
            t   = arg << 20;
            u   = q30_mul(t, t);
            acc = POLY[4];
            for (int k = 3; k >= 0; k--)
                acc = sub_clip(POLY[k], q30_mul(u, acc));
            acc = sub_clip(Q30_ONE, q30_mul(u, acc));
            acc = (acc + 64'd8192) >> 14;
            return (acc > 64'd65536) ? 64'd65536 : acc;
        endfunction

        function t_col_out project_column(t_ray_in r);
            logic [11:0]     diff;
            longint unsigned cd, h;
            int              half, top, bottom;
            t_col_out        c;
            diff = r.ray_angle - heading;
            cd   = (64'(r.ray_distance) * cos_magnitude(diff)) >> 16;
            if (cd == 0) begin
                h = SLICE_MAX;
            end else begin
                h = (64'(TILE) * 64'(plane) * 64'd256) / cd;
                if (h > SLICE_MAX)
                    h = SLICE_MAX;
            end
            half   = int'(h >> 1);
            top    = SCREEN_H / 2 - half;
            bottom = SCREEN_H / 2 + half;
            c.wall_top_raw        = 14'(top);
            c.wall_bottom_raw     = 14'(bottom);
            c.wall_top_clamped    = 9'((top < 0) ? 0 : top);
            c.wall_bottom_clamped = 10'((bottom > SCREEN_H) ? SCREEN_H : bottom);
            c.wall_height         = 14'(h);
            c.sky_present         = (top > 0);
            c.floor_present       = (bottom < SCREEN_H);
            c.wall_shade          = r.hit_vertical;
            c.texture_column      = textured ?
                6'((r.hit_vertical ? r.hit_y : r.hit_x) % TILE) : 6'd0;
            return c;
        endfunction

        function void note_ray(t_ray_in r);
            pending_columns.push_back(project_column(r));
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_column(t_col_out got);
            t_col_out want;
            if (pending_columns.size() == 0) begin
                $error("column result with no request outstanding");
                errors++;
                return;
            end
            want = pending_columns.pop_front();
            compare_field("wall_top_raw", want.wall_top_raw, got.wall_top_raw);
            compare_field("wall_bottom_raw", want.wall_bottom_raw, got.wall_bottom_raw);
            compare_field("wall_top_clamped", want.wall_top_clamped, got.wall_top_clamped);
            compare_field("wall_bottom_clamped", want.wall_bottom_clamped,
                          got.wall_bottom_clamped);
            compare_field("wall_height", want.wall_height, got.wall_height);
            compare_field("sky_present", want.sky_present, got.sky_present);
            compare_field("floor_present", want.floor_present, got.floor_present);
            compare_field("wall_shade", want.wall_shade, got.wall_shade);
            compare_field("texture_column", want.texture_column, got.texture_column);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_ray_in               i_ray       = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_col_out              o_col;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    column_scoreboard sb = new();
    int               send_pct = 0;
    int               recv_pct = 0;
    int               idle_count = 0;
    logic [11:0]      cur_heading;
    t_ray_in          directed_rays[$];

    raycast_wall_column_projection dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ray       (i_ray),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_col       (o_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: check accepted columns, randomise stall, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_column(o_col);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT) begin
                $display("raycast_wall_column_projection verification failed");
                $finish;
            end
        end
        i_stall <= ($urandom_range(99) < recv_pct);
    end

    function automatic t_ray_in make_ray(logic [23:0] ray_len, logic [11:0] ang, logic vert,
                                         logic [15:0] hx, logic [15:0] hy);
        t_ray_in r;
        r.ray_distance = ray_len;
        r.ray_angle    = ang;
        r.hit_vertical = vert;
        r.hit_x        = hx;
        r.hit_y        = hy;
        return r;
    endfunction

    // Mostly rays inside the field of view at wall-like distances, some anywhere
    function automatic t_ray_in random_ray(logic [11:0] heading);
        logic [23:0] ray_len;
        logic [11:0] ang;
        case ($urandom_range(9))
            0:       ray_len = 24'($urandom);
            1:       ray_len = 24'($urandom_range(0, 300));
            default: ray_len = 24'($urandom_range(2000, 400000));
        endcase
        case ($urandom_range(7))
            5:       ang = 12'($urandom);
            6:       ang = heading + 12'(1024 * $urandom_range(1, 3))
                           + 12'($urandom_range(0, 6)) - 12'd3;
            7:       ang = heading + 12'd1024;
            default: ang = heading + 12'($urandom_range(0, 700)) - 12'd350;
        endcase
        return make_ray(ray_len, ang, 1'($urandom_range(1)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)));
    endfunction

    // Offer one request after a random gap; returns once it is accepted
    task automatic send_ray(t_ray_in r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ray   <= r;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_ray(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    // Unused upper bits of the heading and mode registers carry random junk
    task automatic configure(logic [11:0] heading, logic [15:0] plane, logic textured);
        write_reg(CFG_HEADING, {4'($urandom_range(15)), heading});
        write_reg(CFG_PLANE, plane);
        write_reg(CFG_TEXTURED, {15'($urandom_range(32767)), textured});
        i_cfg_we    <= 1'b0;
        cur_heading = heading;
    endtask

    task automatic drain();
        while (sb.pending_columns.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [11:0] h;
        logic [15:0] p;
        logic        t;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero and tiny distances, rows around the screen edges,
        // rays at right angles and behind the viewer, coordinate extremes
        directed_rays.push_back(make_ray(24'd0, 12'd0, 1'b0, 16'd0, 16'd0));
        directed_rays.push_back(make_ray(24'hFFFFFF, 12'd0, 1'b1, 16'hFFFF, 16'hFFFF));
        directed_rays.push_back(make_ray(24'd1, 12'd0, 1'b0, 16'hFFFF, 16'd0));
        directed_rays.push_back(make_ray(24'd16384, 12'd0, 1'b1, 16'd0, 16'hFFFF));
        directed_rays.push_back(make_ray(24'd2560, 12'd0, 1'b0, 16'd63, 16'd64));
        directed_rays.push_back(make_ray(24'd14176, 12'd0, 1'b1, 16'd64, 16'd63));
        directed_rays.push_back(make_ray(24'd14229, 12'd0, 1'b0, 16'd100, 16'd200));
        directed_rays.push_back(make_ray(24'd14203, 12'd0, 1'b1, 16'd300, 16'd400));
        directed_rays.push_back(make_ray(24'd1000, 12'd1024, 1'b0, 16'd5, 16'd6));
        directed_rays.push_back(make_ray(24'd25600, 12'd2048, 1'b1, 16'd7, 16'd8));
        directed_rays.push_back(make_ray(24'd25600, 12'd3072, 1'b0, 16'd9, 16'd10));
        directed_rays.push_back(make_ray(24'd25600, 12'd4095, 1'b1, 16'd11, 16'd12));
        directed_rays.push_back(make_ray(24'd25600, 12'd1, 1'b0, 16'd13, 16'd14));
        directed_rays.push_back(make_ray(24'd25600, 12'd1023, 1'b1, 16'd15, 16'd16));
        directed_rays.push_back(make_ray(24'd25600, 12'd1025, 1'b0, 16'd17, 16'd18));
        directed_rays.push_back(make_ray(24'd25600, 12'd2047, 1'b1, 16'd19, 16'd20));
        directed_rays.push_back(make_ray(24'd25600, 12'd2049, 1'b0, 16'd21, 16'd22));
        directed_rays.push_back(make_ray(24'hFFFFFF, 12'd1024, 1'b1, 16'hAAAA, 16'h5555));
        directed_rays.push_back(make_ray(24'h800000, 12'd512, 1'b0, 16'h5555, 16'hAAAA));
        directed_rays.push_back(make_ray(24'd300, 12'd3500, 1'b1, 16'd1, 16'd65534));

        send_pct = 31;
        recv_pct = 84;
        configure(12'd0, 16'd443, 1'b1);
        foreach (directed_rays[i])
            send_ray(directed_rays[i]);
        i_valid <= 1'b0;
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 3) begin
                send_pct = 31;
                recv_pct = 84;
            end else if (ph < 6) begin
                send_pct = 84;
                recv_pct = 31;
            end else begin
                send_pct = 0;
                recv_pct = 0;
            end
            h = 12'($urandom);
            t = 1'($urandom_range(1));
            p = $urandom_range(1) ? 16'($urandom_range(200, 1000)) : 16'($urandom_range(65535));
            case (ph)
                0: configure(12'd0, 16'd443, 1'b0);
                1: configure(12'd4095, 16'd65535, 1'b1);
                2: configure(h, 16'd1, 1'b1);
                3: configure(h, 16'd0, 1'b0);
                default: configure(h, p, t);
            endcase
            repeat (RAYS_PER_PHASE)
                send_ray(random_ray(cur_heading));
            i_valid <= 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending_columns.size() == 0)
            $display("raycast_wall_column_projection verification clean");
        else
            $display("raycast_wall_column_projection verification failed");
        $finish;
    end

endmodule

### raycast_wall_column_projection.f
rtl/rwcp_pkg.sv
rtl/raycast_wall_column_projection.sv
test/tb_raycast_wall_column_projection.sv
